@@ rtl/dopff_pkg.sv @@
// Shared types and constants of the DoP output frame FIFO.
`default_nettype none
package dopff_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned OUT_LIMIT = 8;

    localparam logic [7:0]  MARK_EVEN    = 8'h05;
    localparam logic [7:0]  MARK_ODD     = 8'hFA;
    localparam logic [15:0] IDLE_PAYLOAD = 16'h6969;
    localparam logic [47:0] MAX48        = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        CMD_PUSH    = 4'd0,
        CMD_RENDER  = 4'd1,
        CMD_BEGIN   = 4'd2,
        CMD_REPLACE = 4'd3,
        CMD_END     = 4'd4,
        CMD_PAUSE   = 4'd5,
        CMD_STOP    = 4'd6,
        CMD_TICK    = 4'd7,
        CMD_STATUS  = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FIFO    = 3'd1,
        ST_SILENCE = 3'd2,
        ST_FULL    = 3'd3,
        ST_REJECT  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_CHANNELS     = 2'd0,
        REG_OUT_CHANNELS = 2'd1,
        REG_PB_FRAMES    = 2'd2,
        REG_PB_TIMEOUT   = 2'd3
    } t_reg;

    typedef struct packed {
        logic [3:0]  command;
        logic [15:0] sample;
        logic [15:0] generation_tag;
        logic        block_start;
        logic        pause_flag;
    } t_in_item;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic [2:0]  status;
        logic [10:0] ready_frames;
        logic [47:0] frames_played;
        logic [31:0] underrun_blocks;
        logic [47:0] underrun_frames;
        logic        drained;
        logic [15:0] generation;
        logic        prebuffering;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } t_cfg_item;

endpackage
`default_nettype wire

@@ rtl/dopff_if.sv @@
// Valid/ready channel interfaces: input items, result items, register writes.
`default_nettype none
interface dopff_in_if
    import dopff_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dopff_out_if
    import dopff_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dopff_cfg_if
    import dopff_pkg::*;
;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/dopff_store.sv @@
// Sample store: one write port, one read port with registered read data.
`default_nettype none
module dopff_store
    import dopff_pkg::*;
#(
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [SAMPLE_W-1:0]        i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [SAMPLE_W-1:0]        o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/dop_output_frame_fifo.sv @@
// DoP output frame FIFO: command decode, session/prebuffer/underrun state, frame emission.
//
// Channels: i_in takes one command item per transfer (push, render, session
// control, tick, status); o_out gives the results; i_cfg writes the four
// configuration registers and is always ready.
// Every command except render gives one result, loaded into the output
// register at the transfer and valid on the cycle after it. A render gives
// out_channels words with last set on the final one. The frame decision is
// registered at the transfer, together with the store read for a FIFO frame,
// and the first word is loaded into the output register from them, for a
// FIFO frame and a silent frame alike; then one word per cycle while the
// receiver takes them. A new item is taken once the previous item's last
// result is loaded and the output register is free, so a render blocks
// input until its last word is loaded. The store has a single read port,
// which sets the one-word-per-cycle render rate.
// Status fields of a result reflect the state after its item; they are held
// steady while the result waits, since no new item is taken meanwhile.
// Reset clears all control state and counters and loads the register
// defaults; the sample store keeps its contents and needs no clearing pass.
// A stalled receiver holds the result and blocks further input.
`default_nettype none
module dop_output_frame_fifo
    import dopff_pkg::*;
#(
    parameter int unsigned CAPACITY_FRAMES = 1024,
    parameter int unsigned MAX_CHANNELS    = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dopff_in_if.sink    i_in,
    dopff_out_if.source o_out,
    dopff_cfg_if.sink   i_cfg
);

    localparam int unsigned DEPTH = CAPACITY_FRAMES * MAX_CHANNELS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned FR_W  = $clog2(CAPACITY_FRAMES);
    localparam int unsigned RC_W  = $clog2(CAPACITY_FRAMES + 1);
    localparam int unsigned WC_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned OC_W  = $clog2(OUT_LIMIT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAY,
        S_SIL
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0]  r_channels;
    logic [3:0]  r_out_channels;
    logic [10:0] r_pb_frames;
    logic [15:0] r_pb_timeout;

    // FIFO and session state
    logic [FR_W-1:0] r_rd_frame;
    logic [FR_W-1:0] r_wr_frame;
    logic [RC_W-1:0] r_ready_cnt;
    logic [WC_W-1:0] r_wr_chan;
    logic            r_parity;
    logic            r_paused;
    logic            r_ended;
    logic            r_stop;
    logic            r_audio;
    logic            r_prebuf;
    logic [15:0]     r_countdown;
    logic [15:0]     r_gen;
    logic            r_blk_silent;
    logic            r_blk_counting;
    logic [47:0]     r_played;
    logic [31:0]     r_ub;
    logic [47:0]     r_uf;

    // emission
    logic [OC_W-1:0] r_c;
    logic [OC_W-1:0] r_oc_last;
    logic [7:0]      r_marker;
    logic [FR_W-1:0] r_base_frame;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_last;
    logic [2:0]  r_out_status;

    logic                in_xfer;
    logic                slot_free;
    logic [CH_W-1:0]     ch_eff;
    logic [3:0]          oc_eff;
    t_cmd                cmd;

    logic                push_stale;
    logic                push_full;
    logic                push_ok;
    logic                push_done;

    logic                n_silent;
    logic                n_counting;
    logic                n_prebuf;
    logic                rnd_play;
    logic                rnd_ub;
    logic                rnd_uf;

    logic [FR_W-1:0]     rd_frame_sel;
    logic [OC_W-1:0]     rd_c;
    logic [WC_W-1:0]     rd_src;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic [31:0]         ready_ext;

    function automatic logic [FR_W-1:0] frame_inc(input logic [FR_W-1:0] f);
        logic [FR_W-1:0] r;
        if (f == FR_W'(CAPACITY_FRAMES - 1)) begin
            r = '0;
        end else begin
            r = f + FR_W'(1);
        end
        return r;
    endfunction

    assign cmd       = t_cmd'(i_in.data.command);
    assign slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free;
    assign in_xfer   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_channels == 4'd0) begin
            ch_eff = CH_W'(1);
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            ch_eff = CH_W'(MAX_CHANNELS);
        end else begin
            ch_eff = CH_W'(r_channels);
        end
        if (r_out_channels == 4'd0) begin
            oc_eff = 4'd1;
        end else if (32'(r_out_channels) > OUT_LIMIT) begin
            oc_eff = 4'(OUT_LIMIT);
        end else begin
            oc_eff = r_out_channels;
        end
    end

    // push checks: stale tag or stop first, then full
    assign push_stale = (i_in.data.generation_tag != r_gen) || r_stop;
    assign push_full  = (r_ready_cnt == RC_W'(CAPACITY_FRAMES));
    assign push_ok    = !push_stale && !push_full;
    assign push_done  = (32'(r_wr_chan) + 32'd1) >= 32'(ch_eff);
    assign wr_addr    = AW'(32'(r_wr_frame) * MAX_CHANNELS + 32'(r_wr_chan));

    // block decision for a render
    always_comb begin
        n_silent   = r_blk_silent;
        n_counting = r_blk_counting;
        n_prebuf   = r_prebuf;
        rnd_play   = 1'b0;
        rnd_ub     = 1'b0;
        rnd_uf     = 1'b0;
        if (i_in.data.block_start) begin
            n_silent   = 1'b0;
            n_counting = 1'b0;
            if (r_paused) begin
                n_silent = 1'b1;
            end else if (r_prebuf) begin
                if ((32'(r_ready_cnt) >= 32'(r_pb_frames)) || (r_pb_timeout == 16'd0)
                        || (r_countdown == 16'd0) || r_ended) begin
                    n_prebuf = 1'b0;
                end else begin
                    n_silent = 1'b1;
                end
            end
        end
        if (!n_silent) begin
            if (r_ready_cnt == '0) begin
                // ran dry: rest of the block is silence
                n_silent = 1'b1;
                if (!r_ended && r_audio) begin
                    n_counting = 1'b1;
                    rnd_ub     = 1'b1;
                end
                rnd_uf = n_counting;
            end else begin
                rnd_play = 1'b1;
            end
        end else begin
            rnd_uf = n_counting;
        end
    end

    // store read: first word at the render transfer, the rest as words leave
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_frame_sel = r_rd_frame;
            rd_c         = '0;
        end else begin
            rd_frame_sel = r_base_frame;
            rd_c         = r_c + OC_W'(1);
        end
        if (32'(rd_c) < 32'(ch_eff)) begin
            rd_src = WC_W'(rd_c);
        end else begin
            rd_src = WC_W'(ch_eff - CH_W'(1));
        end
        rd_addr = AW'(32'(rd_frame_sel) * MAX_CHANNELS + 32'(rd_src));
        rd_en   = (in_xfer && (cmd == CMD_RENDER) && rnd_play)
               || ((r_state == S_PLAY) && slot_free && (r_c != r_oc_last));
    end

    dopff_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && (cmd == CMD_PUSH) && push_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.data.sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels     <= 4'd2;
            r_out_channels <= 4'd2;
            r_pb_frames    <= 11'd0;
            r_pb_timeout   <= 16'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg'(i_cfg.data.index))
                REG_CHANNELS:     r_channels     <= i_cfg.data.value[3:0];
                REG_OUT_CHANNELS: r_out_channels <= i_cfg.data.value[3:0];
                REG_PB_FRAMES:    r_pb_frames    <= i_cfg.data.value[10:0];
                REG_PB_TIMEOUT:   r_pb_timeout   <= i_cfg.data.value;
                default:          r_pb_timeout   <= r_pb_timeout;
            endcase
        end
    end

    // state machine, FIFO state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rd_frame     <= '0;
            r_wr_frame     <= '0;
            r_ready_cnt    <= '0;
            r_wr_chan      <= '0;
            r_parity       <= 1'b0;
            r_paused       <= 1'b0;
            r_ended        <= 1'b0;
            r_stop         <= 1'b0;
            r_audio        <= 1'b0;
            r_prebuf       <= 1'b0;
            r_countdown    <= 16'd0;
            r_gen          <= 16'd0;
            r_blk_silent   <= 1'b0;
            r_blk_counting <= 1'b0;
            r_played       <= 48'd0;
            r_ub           <= 32'd0;
            r_uf           <= 48'd0;
            r_c            <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (cmd == CMD_RENDER) begin
                            r_parity       <= ~r_parity;
                            r_marker       <= r_parity ? MARK_ODD : MARK_EVEN;
                            r_oc_last      <= OC_W'(oc_eff - 4'd1);
                            r_c            <= '0;
                            r_base_frame   <= r_rd_frame;
                            r_blk_silent   <= n_silent;
                            r_blk_counting <= n_counting;
                            r_prebuf       <= n_prebuf;
                            if (rnd_ub && (r_ub != MAX32)) begin
                                r_ub <= r_ub + 32'd1;
                            end
                            if (rnd_uf && (r_uf != MAX48)) begin
                                r_uf <= r_uf + 48'd1;
                            end
                            if (rnd_play) begin
                                r_rd_frame  <= frame_inc(r_rd_frame);
                                r_ready_cnt <= r_ready_cnt - RC_W'(1);
                                if (r_played != MAX48) begin
                                    r_played <= r_played + 48'd1;
                                end
                                r_state <= S_PLAY;
                            end else begin
                                r_state <= S_SIL;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_word  <= 32'd0;
                            r_out_last  <= 1'b1;
                            r_out_status <= ST_DONE;
                            case (cmd)
                                CMD_PUSH: begin
                                    if (push_stale) begin
                                        r_out_status <= ST_REJECT;
                                    end else if (push_full) begin
                                        r_out_status <= ST_FULL;
                                    end else begin
                                        r_audio <= 1'b1;
                                        if (push_done) begin
                                            r_wr_chan   <= '0;
                                            r_wr_frame  <= frame_inc(r_wr_frame);
                                            r_ready_cnt <= r_ready_cnt + RC_W'(1);
                                        end else begin
                                            r_wr_chan <= r_wr_chan + WC_W'(1);
                                        end
                                    end
                                end
                                CMD_BEGIN: begin
                                    r_gen       <= r_gen + 16'd1;
                                    r_rd_frame  <= '0;
                                    r_wr_frame  <= '0;
                                    r_ready_cnt <= '0;
                                    r_wr_chan   <= '0;
                                    r_countdown <= (r_pb_timeout != 16'd0) ? r_pb_timeout
                                                                           : 16'd1;
                                    r_played    <= 48'd0;
                                    r_ub        <= 32'd0;
                                    r_uf        <= 48'd0;
                                    r_paused    <= 1'b0;
                                    r_ended     <= 1'b0;
                                    r_stop      <= 1'b0;
                                    r_audio     <= 1'b0;
                                    r_prebuf    <= (r_pb_frames != 11'd0);
                                end
                                CMD_REPLACE: begin
                                    r_gen       <= r_gen + 16'd1;
                                    r_rd_frame  <= '0;
                                    r_wr_frame  <= '0;
                                    r_ready_cnt <= '0;
                                    r_wr_chan   <= '0;
                                    r_paused    <= i_in.data.pause_flag;
                                    r_ended     <= 1'b0;
                                    r_stop      <= 1'b0;
                                    r_audio     <= 1'b0;
                                    r_prebuf    <= 1'b0;
                                end
                                CMD_END:   r_ended  <= 1'b1;
                                CMD_PAUSE: r_paused <= i_in.data.pause_flag;
                                CMD_STOP:  r_stop   <= 1'b1;
                                CMD_TICK: begin
                                    if (r_countdown != 16'd0) begin
                                        r_countdown <= r_countdown - 16'd1;
                                    end
                                end
                                default: r_out_status <= ST_DONE;
                            endcase
                        end
                    end
                end
                S_PLAY: begin
                    if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_word   <= {8'd0, r_marker, rd_data};
                        r_out_last   <= (r_c == r_oc_last);
                        r_out_status <= ST_FIFO;
                        r_c          <= r_c + OC_W'(1);
                        if (r_c == r_oc_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SIL: begin
                    if (slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_word   <= {8'd0, r_marker, IDLE_PAYLOAD};
                        r_out_last   <= (r_c == r_oc_last);
                        r_out_status <= ST_SILENCE;
                        r_c          <= r_c + OC_W'(1);
                        if (r_c == r_oc_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign ready_ext = 32'(r_ready_cnt);

    assign o_out.valid                = r_out_valid;
    assign o_out.data.word            = r_out_word;
    assign o_out.data.last            = r_out_last;
    assign o_out.data.status          = r_out_status;
    assign o_out.data.ready_frames    = ready_ext[10:0];
    assign o_out.data.frames_played   = r_played;
    assign o_out.data.underrun_blocks = r_ub;
    assign o_out.data.underrun_frames = r_uf;
    assign o_out.data.drained         = r_ended && (r_ready_cnt == '0);
    assign o_out.data.generation      = r_gen;
    assign o_out.data.prebuffering    = r_prebuf;

`ifndef SYNTHESIS
    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ready_cnt) <= CAPACITY_FRAMES)
        else $error("ready frame count above capacity");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a result is stalled");

    a_fifo_word_in_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FIFO) && !r_out_last) |-> (r_state == S_PLAY))
        else $error("FIFO frame word outside frame emission");

    a_play_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (cmd == CMD_RENDER) && rnd_play) |-> (r_ready_cnt != '0))
        else $error("frame played from an empty FIFO");
`endif

endmodule
`default_nettype wire
